[hdl/dqsm_pkg.sv]
// Shared types, constants and speed packing for the dual quadrature speed meter.
// No dependencies; used by dqsm_front, dqsm_back and the top level.
package dqsm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SCALE_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int WORD_WIDTH  = 16;
    localparam int LOW_BITS    = 14;
    localparam int MAG_WIDTH   = COUNT_WIDTH + 1;
    localparam int PROD_WIDTH  = MAG_WIDTH + SCALE_WIDTH;
    localparam int Q_WIDTH     = PROD_WIDTH - FRAC_BITS;

    localparam int SQ_DEPTH    = 4;
    localparam int SQ_PTR      = $clog2(SQ_DEPTH);
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR      = $clog2(RQ_DEPTH);

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);
    localparam logic [Q_WIDTH-1:0]     MAX_POS     = Q_WIDTH'(32767);
    localparam logic [Q_WIDTH-1:0]     MAX_NEG_MAG = Q_WIDTH'(32768);

    // item codes
    localparam logic OP_EDGE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic WHEEL_LEFT  = 1'b0;
    localparam logic WHEEL_RIGHT = 1'b1;

    // direction codes, word bits 15:14
    localparam logic [1:0] DIR_FORWARD = 2'b01;
    localparam logic [1:0] DIR_REVERSE = 2'b10;

    typedef logic signed [COUNT_WIDTH-1:0] t_count;

    // one latched sample, front to back
    typedef struct packed {
        t_count     left_count;
        t_count     right_count;
        logic [1:0] left_dir;
        logic [1:0] right_dir;
    } t_sample;

    // one wheel after the multiply stage
    typedef struct packed {
        logic                  neg;
        logic [PROD_WIDTH-1:0] prod;
        logic [1:0]            dir;
        logic [WORD_WIDTH-1:0] pulses;
    } t_wheel_prod;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] left_speed_word;
        logic [WORD_WIDTH-1:0] right_speed_word;
        logic [WORD_WIDTH-1:0] left_pulses;
        logic [WORD_WIDTH-1:0] right_pulses;
    } t_result;

    // |count| as an unsigned value one bit wider than the count
    function automatic logic [MAG_WIDTH-1:0] count_mag(input t_count c);
        logic [MAG_WIDTH-1:0] ext;
        ext = {c[COUNT_WIDTH-1], c};
        return c[COUNT_WIDTH-1] ? (MAG_WIDTH'(0) - ext) : ext;
    endfunction

    // clamp the truncated quotient and pack the direction bits
    function automatic logic [WORD_WIDTH-1:0] speed_word(
        input logic               neg,
        input logic [Q_WIDTH-1:0] q,
        input logic [1:0]         dir
    );
        logic [WORD_WIDTH-1:0] m;
        if (neg) begin
            m = (q > MAX_NEG_MAG) ? WORD_WIDTH'(32768) : (WORD_WIDTH'(0) - WORD_WIDTH'(q));
        end else begin
            m = (q > MAX_POS) ? WORD_WIDTH'(32767) : WORD_WIDTH'(q);
        end
        if (m == '0) begin
            return {dir, LOW_BITS'(0)};
        end else if (neg) begin
            return {DIR_REVERSE, m[LOW_BITS-1:0]};
        end else begin
            return {DIR_FORWARD, m[LOW_BITS-1:0]};
        end
    endfunction

endpackage

[hdl/dqsm_front.sv]
// Front end: edge counters for both wheels and the sample queue to the back end.
// Depends on dqsm_pkg.
module dqsm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic              i_wheel,
    input  logic              i_phase_a,
    input  logic              i_phase_b,
    input  logic [1:0]        i_left_target_direction,
    input  logic [1:0]        i_right_target_direction,
    output logic              o_full,
    output logic              o_sample_valid,
    output dqsm_pkg::t_sample o_sample,
    input  logic              i_sample_take
);
    import dqsm_pkg::*;

    t_count             r_left_cnt, n_left_cnt;
    t_count             r_right_cnt, n_right_cnt;
    t_sample            r_mem [SQ_DEPTH];
    logic [SQ_PTR-1:0]  r_wr, r_rd;
    logic [SQ_PTR:0]    r_fill;
    logic               is_edge, is_tick, step_up, sq_pop;
    t_count             step;
    t_sample            new_sample;

    assign is_edge = i_accept && (i_operation == OP_EDGE);
    assign is_tick = i_accept && (i_operation == OP_TICK);
    assign step_up = (i_phase_a == i_phase_b);
    assign step    = step_up ? t_count'(1) : t_count'(-1);

    always_comb begin
        n_left_cnt  = r_left_cnt;
        n_right_cnt = r_right_cnt;
        if (is_tick) begin
            n_left_cnt  = '0;
            n_right_cnt = '0;
        end else if (is_edge) begin
            if (i_wheel == WHEEL_RIGHT) begin
                n_right_cnt = r_right_cnt + step;
            end else begin
                n_left_cnt = r_left_cnt + step;
            end
        end
    end

    assign new_sample = '{left_count:  r_left_cnt,
                          right_count: r_right_cnt,
                          left_dir:    i_left_target_direction,
                          right_dir:   i_right_target_direction};

    assign sq_pop         = i_sample_take && (r_fill != '0);
    assign o_full         = (r_fill == (SQ_PTR+1)'(SQ_DEPTH));
    assign o_sample_valid = (r_fill != '0);
    assign o_sample       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_fill      <= '0;
        end else begin
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            if (is_tick) begin
                r_wr <= r_wr + 1'b1;
            end
            if (sq_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (SQ_PTR+1)'(is_tick) - (SQ_PTR+1)'(sq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_mem[r_wr] <= new_sample;
        end
    end

endmodule

[hdl/dqsm_back.sv]
// Back end: scale multiply stage, clamp and pack stage, and the result queue.
// Depends on dqsm_pkg.
module dqsm_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [dqsm_pkg::SCALE_WIDTH-1:0]     i_scale,
    input  logic                                 i_sample_valid,
    input  dqsm_pkg::t_sample                    i_sample,
    output logic                                 o_sample_take,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output dqsm_pkg::t_result                    o_result
);
    import dqsm_pkg::*;

    logic              r_s1_valid;
    t_wheel_prod       r_s1_left, r_s1_right;
    t_wheel_prod       n_left, n_right;
    t_result           r_mem [RQ_DEPTH];
    logic [RQ_PTR-1:0] r_wr, r_rd;
    logic [RQ_PTR:0]   r_fill;
    logic              rq_full, rq_pop, rq_push, s1_load;
    logic [MAG_WIDTH-1:0] left_mag, right_mag;
    t_result           packed_res;

    assign rq_full = (r_fill == (RQ_PTR+1)'(RQ_DEPTH));
    assign o_empty = (r_fill == '0);
    assign rq_pop  = i_pop && !o_empty;
    assign rq_push = r_s1_valid && (!rq_full || rq_pop);
    assign s1_load = !r_s1_valid || rq_push;
    assign o_sample_take = i_sample_valid && s1_load;

    // stage 1: |count| times scale, one 17x24 product per wheel
    assign left_mag  = count_mag(i_sample.left_count);
    assign right_mag = count_mag(i_sample.right_count);

    always_comb begin
        n_left.neg     = i_sample.left_count[COUNT_WIDTH-1];
        n_left.prod    = PROD_WIDTH'(left_mag) * PROD_WIDTH'(i_scale);
        n_left.dir     = i_sample.left_dir;
        n_left.pulses  = WORD_WIDTH'($unsigned(i_sample.left_count));
        n_right.neg    = i_sample.right_count[COUNT_WIDTH-1];
        n_right.prod   = PROD_WIDTH'(right_mag) * PROD_WIDTH'(i_scale);
        n_right.dir    = i_sample.right_dir;
        n_right.pulses = WORD_WIDTH'($unsigned(i_sample.right_count));
    end

    // stage 2: drop the fraction, clamp, pack
    always_comb begin
        packed_res.left_speed_word  = speed_word(r_s1_left.neg,
            r_s1_left.prod[PROD_WIDTH-1:FRAC_BITS], r_s1_left.dir);
        packed_res.right_speed_word = speed_word(r_s1_right.neg,
            r_s1_right.prod[PROD_WIDTH-1:FRAC_BITS], r_s1_right.dir);
        packed_res.left_pulses      = r_s1_left.pulses;
        packed_res.right_pulses     = r_s1_right.pulses;
    end

    assign o_result = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_fill     <= '0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_sample_valid;
            end
            if (rq_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rq_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (RQ_PTR+1)'(rq_push) - (RQ_PTR+1)'(rq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sample_take) begin
            r_s1_left  <= n_left;
            r_s1_right <= n_right;
        end
        if (rq_push) begin
            r_mem[r_wr] <= packed_res;
        end
    end

endmodule

[hdl/dual_quadrature_speed_meter_top.sv]
// Top level of the dual quadrature speed meter: scale register and the two halves.
// Depends on dqsm_pkg, dqsm_front and dqsm_back.
//
// Counts x2-decoded phase-A edges of a left and a right quadrature encoder and,
// on every sample tick, reports one word set: the two counts latched over the
// period and two packed speed words. An edge item (operation 0) steps the
// chosen wheel's 16-bit wrapping count up when A equals B and down otherwise;
// it gives no result. A tick item (operation 1) latches both counts, clears
// them and gives one result. Speed m = count * speed_scale / 2^16, truncated
// toward zero and clamped to -32768..32767; the word is 01 plus m[13:0] for a
// positive m, 10 plus m[13:0] for a negative m, and the target direction bits
// over zeros when m is zero. speed_scale (Q16, reset 65536) is written through
// the cfg channel, which is always ready; write it only while the block is idle.
// Rate: one item accepted per clock while full is low. Edges act in the cycle they
// are taken; a tick result passes the sample queue, the multiply stage (two 17x24
// products) and the pack into the result queue before it shows on the result side.
// Four-word queues sit between the front counters and the multiply stage and at
// the output, so push only sees full once nine ticks pile up behind a stalled
// pop (four per queue, one in the multiply stage).
module dual_quadrature_speed_meter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic        i_wheel,
    input  logic        i_phase_a,
    input  logic        i_phase_b,
    input  logic [1:0]  i_left_target_direction,
    input  logic [1:0]  i_right_target_direction,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_left_speed_word,
    output logic [15:0] o_right_speed_word,
    output logic signed [15:0] o_left_pulses,
    output logic signed [15:0] o_right_pulses,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dqsm_pkg::SCALE_WIDTH-1:0] i_cfg_data
);
    import dqsm_pkg::*;

    logic [SCALE_WIDTH-1:0] r_scale;
    logic                   in_accept;
    logic                   sample_valid, sample_take;
    t_sample                sample;
    t_result                result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    // front: counters, tick latch, sample queue
    dqsm_front u_front (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_accept                 (in_accept),
        .i_operation              (i_operation),
        .i_wheel                  (i_wheel),
        .i_phase_a                (i_phase_a),
        .i_phase_b                (i_phase_b),
        .i_left_target_direction  (i_left_target_direction),
        .i_right_target_direction (i_right_target_direction),
        .o_full                   (full),
        .o_sample_valid           (sample_valid),
        .o_sample                 (sample),
        .i_sample_take            (sample_take)
    );

    // back: scale, clamp, pack, result queue
    dqsm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scale        (r_scale),
        .i_sample_valid (sample_valid),
        .i_sample       (sample),
        .o_sample_take  (sample_take),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_result       (result)
    );

    assign o_left_speed_word  = result.left_speed_word;
    assign o_right_speed_word = result.right_speed_word;
    assign o_left_pulses      = $signed(result.left_pulses);
    assign o_right_pulses     = $signed(result.right_pulses);

endmodule

[sim/tb_top.sv]
// Self-checking bench for the dual quadrature speed meter: drives edge and tick words,
// predicts each speed result in-bench and checks it field by field.
// Depends on dqsm_pkg and dual_quadrature_speed_meter_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dqsm_pkg::t_count;
    import dqsm_pkg::t_result;
    import dqsm_pkg::OP_EDGE;
    import dqsm_pkg::OP_TICK;
    import dqsm_pkg::WHEEL_LEFT;
    import dqsm_pkg::WHEEL_RIGHT;
    import dqsm_pkg::DIR_FORWARD;
    import dqsm_pkg::DIR_REVERSE;
    import dqsm_pkg::SCALE_WIDTH;
    import dqsm_pkg::SCALE_RESET;

    // ---------------------------------------------------------------- DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   i_operation = 1'b0;
    logic                   i_wheel = 1'b0;
    logic                   i_phase_a = 1'b0;
    logic                   i_phase_b = 1'b0;
    logic [1:0]             i_left_target_direction = 2'b00;
    logic [1:0]             i_right_target_direction = 2'b00;
    logic                   pop = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [SCALE_WIDTH-1:0] i_cfg_data = '0;
    wire                    full;
    wire                    empty;
    wire  [15:0]            o_left_speed_word;
    wire  [15:0]            o_right_speed_word;
    wire  signed [15:0]     o_left_pulses;
    wire  signed [15:0]     o_right_pulses;
    wire                    o_cfg_ready;

    dual_quadrature_speed_meter_top u_top (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .push                     (push),
        .full                     (full),
        .i_operation              (i_operation),
        .i_wheel                  (i_wheel),
        .i_phase_a                (i_phase_a),
        .i_phase_b                (i_phase_b),
        .i_left_target_direction  (i_left_target_direction),
        .i_right_target_direction (i_right_target_direction),
        .empty                    (empty),
        .pop                      (pop),
        .o_left_speed_word        (o_left_speed_word),
        .o_right_speed_word       (o_right_speed_word),
        .o_left_pulses            (o_left_pulses),
        .o_right_pulses           (o_right_pulses),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_data               (i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor state
    // Edge counters and scale as the block should hold them, plus the words still owed.
    t_count                 left_count = '0;
    t_count                 right_count = '0;
    logic [SCALE_WIDTH-1:0] scale_reg = SCALE_RESET;
    t_result                speed_expect_q[$];

    bit          idle_en = 1'b1;   // random idling on both sides
    int unsigned pop_hold = 0;     // cycles left in a forced receiver hold-off
    int          err_count = 0;
    int          words_seen = 0;
    int          items_sent = 0;

    // m = count * scale / 2^16, truncated toward zero, clamped to 16 bits signed,
    // then packed: 01/10 plus m[13:0], or the target direction over zeros when m is 0.
    function automatic logic [15:0] speed_word_of(input t_count cnt,
                                                  input logic [SCALE_WIDTH-1:0] scale,
                                                  input logic [1:0] dir);
        logic signed [63:0] cval;
        logic signed [63:0] mag;
        logic signed [63:0] sc;
        logic signed [63:0] quo;
        logic signed [63:0] m;
        cval = cnt;
        mag  = (cval < 0) ? -cval : cval;
        sc   = {40'd0, scale};
        quo  = (mag * sc) >>> 16;
        if (cval < 0) begin
            m = (quo > 32768) ? -64'sd32768 : -quo;
        end else begin
            m = (quo > 32767) ? 64'sd32767 : quo;
        end
        if (m > 0) begin
            return {DIR_FORWARD, m[13:0]};
        end else if (m < 0) begin
            return {DIR_REVERSE, m[13:0]};
        end
        return {dir, 14'd0};
    endfunction

    // Apply one accepted word to the predictor.
    function automatic void model_take(input logic op, input logic wheel,
                                       input logic a, input logic b,
                                       input logic [1:0] ldir, input logic [1:0] rdir);
        t_result r;
        if (op == OP_EDGE) begin
            // x2 decode: A == B counts up, otherwise down; 16-bit wrap
            if (wheel == WHEEL_RIGHT) begin
                right_count = (a == b) ? right_count + 16'sd1 : right_count - 16'sd1;
            end else begin
                left_count = (a == b) ? left_count + 16'sd1 : left_count - 16'sd1;
            end
        end else begin
            r.left_speed_word  = speed_word_of(left_count, scale_reg, ldir);
            r.right_speed_word = speed_word_of(right_count, scale_reg, rdir);
            r.left_pulses      = left_count;
            r.right_pulses     = right_count;
            speed_expect_q.push_back(r);
            left_count  = '0;
            right_count = '0;
        end
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_error(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got 0x%04h, expected 0x%04h (word %0d)",
                                   name, got, want, words_seen));
        end
    endtask

    // Each popped word is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            words_seen++;
            if (speed_expect_q.size() == 0) begin
                report_error($sformatf("result word %0d with nothing expected", words_seen));
            end else begin
                want = speed_expect_q.pop_front();
                check_field("left_speed_word",  o_left_speed_word,  want.left_speed_word);
                check_field("right_speed_word", o_right_speed_word, want.right_speed_word);
                check_field("left_pulses",      o_left_pulses,      want.left_pulses);
                check_field("right_pulses",     o_right_pulses,     want.right_pulses);
            end
        end
    end

    // Receiver: random pop, solid pop when idling is off, or a counted hold-off.
    always @(negedge i_clk) begin
        if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if (idle_en) begin
            pop <= ($urandom_range(99) >= 37);
        end else begin
            pop <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- sender side
    // Offer one word; returns at the edge where it was taken.
    task automatic send_item(input logic op, input logic wheel, input logic a,
                             input logic b, input logic [1:0] ldir,
                             input logic [1:0] rdir);
        while (idle_en && $urandom_range(99) < 37) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push                     <= 1'b1;
        i_operation              <= op;
        i_wheel                  <= wheel;
        i_phase_a                <= a;
        i_phase_b                <= b;
        i_left_target_direction  <= ldir;
        i_right_target_direction <= rdir;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        model_take(op, wheel, a, b, ldir, rdir);
        items_sent++;
    endtask

    // Edge on one wheel in the given direction, other fields random.
    task automatic send_edge(input logic wheel, input logic up);
        logic a;
        a = 1'($urandom_range(1));
        send_item(OP_EDGE, wheel, a, up ? a : ~a, 2'($urandom_range(3)),
                  2'($urandom_range(3)));
    endtask

    // Tick with the ignored fields random too.
    task automatic send_tick();
        send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3)));
    endtask

    // Stop offering, wait for every owed word, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (speed_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Scale register write, only with the block idle.
    task automatic write_scale(input logic [SCALE_WIDTH-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        scale_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests
    // Ticks straight after reset: zero counts, so every word is the target direction.
    task automatic test_reset_ticks();
        for (int d = 0; d < 4; d++) begin
            send_item(OP_TICK, d[0], d[1], ~d[0], 2'(d), 2'(3 - d));
        end
    endtask

    // All four A/B combinations on each wheel, then a net count on both wheels.
    task automatic test_edge_directions();
        for (int w = 0; w < 2; w++) begin
            for (int ab = 0; ab < 4; ab++) begin
                send_item(OP_EDGE, w[0], ab[1], ab[0], 2'($urandom_range(3)),
                          2'($urandom_range(3)));
            end
        end
        send_tick();
        repeat (3) send_edge(WHEEL_LEFT, 1'b1);
        repeat (2) send_edge(WHEEL_RIGHT, 1'b0);
        // tick with wheel and phase bits all set; they must not matter
        send_item(OP_TICK, 1'b1, 1'b1, 1'b1, 2'b11, 2'b11);
        send_item(OP_TICK, 1'b1, 1'b1, 1'b1, 2'b11, 2'b00);
    endtask

    // Full scale with +130 on the left and -129 on the right: both speeds clamp.
    task automatic test_speed_clamp();
        write_scale('1);
        idle_en = 1'b0;
        for (int i = 0; i < 130; i++) begin
            send_edge(WHEEL_LEFT, 1'b1);
            if (i < 129) send_edge(WHEEL_RIGHT, 1'b0);
        end
        send_tick();
        idle_en = 1'b1;
    endtask

    // Zero scale, full scale and a half scale where truncation hits zero.
    task automatic test_scale_extremes();
        write_scale('0);
        repeat (2) send_edge(WHEEL_LEFT, 1'b1);
        send_edge(WHEEL_RIGHT, 1'b0);
        send_tick();
        write_scale('1);
        send_edge(WHEEL_LEFT, 1'b1);
        send_edge(WHEEL_RIGHT, 1'b0);
        send_tick();
        write_scale(24'h008000);
        send_edge(WHEEL_LEFT, 1'b1);
        send_edge(WHEEL_RIGHT, 1'b0);
        send_tick();
        repeat (3) send_edge(WHEEL_LEFT, 1'b0);
        repeat (3) send_edge(WHEEL_RIGHT, 1'b1);
        send_tick();
    endtask

    // Receiver stops long enough for both queues to fill and full to push back.
    task automatic test_backpressure();
        write_scale(SCALE_RESET);
        idle_en  = 1'b0;
        pop_hold = 300;
        repeat (24) begin
            send_edge(1'($urandom_range(1)), 1'($urandom_range(1)));
            send_tick();
        end
        idle_en = 1'b1;
    endtask

    // Bursts of mostly same-direction edges closed by a tick, with some stray words.
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned burst;
        logic        up_l;
        logic        up_r;
        logic        wh;
        logic        up;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_scale(SCALE_RESET);
                1: write_scale(24'($urandom_range(24'hFFFFFF)));
                2: write_scale(24'($urandom_range(24'h01FFFF)));
                3: write_scale('1);
                4: write_scale(24'($urandom_range(24'h000FFF)));
                default: write_scale(24'($urandom()));
            endcase
            idle_en   = (ph != 2);   // one whole phase without any idling
            phase_end = items_sent + 40;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 85) begin
                    burst = ($urandom_range(24) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 15);
                    up_l  = 1'($urandom_range(1));
                    up_r  = 1'($urandom_range(1));
                    repeat (burst) begin
                        wh = 1'($urandom_range(1));
                        up = wh ? up_r : up_l;
                        if ($urandom_range(9) == 0) up = ~up;   // jitter
                        send_edge(wh, up);
                    end
                    send_tick();
                end else begin
                    send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              2'($urandom_range(3)), 2'($urandom_range(3)));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    // ---------------------------------------------------------------- run
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_ticks();
        test_edge_directions();
        test_speed_clamp();
        test_scale_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop: well above the slowest legal run.
    initial begin
        #400_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
